FILE: hw/rtl/thq_pkg.sv
// Shared types and constants for the total-order hold-back queue.
package thq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DRAIN_LIMIT = 16;
    localparam int DRN_W       = $clog2(DRAIN_LIMIT + 1);

    localparam logic UNDELIVERABLE = 1'b0;
    localparam logic DELIVERABLE   = 1'b1;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_MARK = 1'b1;

    localparam logic KIND_MSG    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_MARKED    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_EMIT,
        S_STATUS
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;       // capture request fields
        logic             scan_clr;   // restart a scan at slot zero
        logic             scan_step;  // examine one slot
        logic             do_add;     // write the free slot found
        logic             do_mark;    // update the matching slot
        logic             emit_head;  // present and remove the head
        logic             emit_stat;  // present the status item
        logic [1:0]       stat_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             req_type;
        logic             scan_done;  // last slot examined this cycle
        logic             found;      // free slot or match was found
        logic             head_ok;    // head exists and is deliverable
    } t_sts;

endpackage

FILE: hw/rtl/thq_ctrl.sv
// Controller state machine of the hold-back queue.
module thq_ctrl
    import thq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic [DRN_W-1:0] r_drn, n_drn;
    logic [1:0] r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drn   <= '0;
            r_code  <= ST_ADDED;
        end else begin
            r_state <= n_state;
            r_drn   <= n_drn;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_drn   = r_drn;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.stat_code = r_code;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.req_type == REQ_ADD) begin
                        o_cmd.do_add = i_sts.found;
                        n_code  = i_sts.found ? ST_ADDED : ST_FULL;
                        n_state = S_STATUS;
                    end else if (i_sts.found) begin
                        o_cmd.do_mark  = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_code  = ST_MARKED;
                        n_drn   = '0;
                        n_state = S_HEAD;
                    end else begin
                        n_code  = ST_NOT_FOUND;
                        n_state = S_STATUS;
                    end
                end
            end
            S_HEAD: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.head_ok && (r_drn < DRN_W'(DRAIN_LIMIT))) begin
                    o_cmd.emit_head = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_drn   = r_drn + 1'b1;
                    n_state = S_HEAD;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                o_cmd.emit_stat = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/thq_dp.sv
// Datapath of the hold-back queue: slot storage, slot scan and result register.
module thq_dp
    import thq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_type,
    input  logic [7:0]  i_sender_id,
    input  logic [31:0] i_msg_id,
    input  logic [31:0] i_seq_num,
    input  logic [7:0]  i_proposer_id,
    input  logic [7:0]  i_origin_process,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_sender,
    output logic [31:0] o_out_msg,
    output logic [31:0] o_out_seq,
    output logic [7:0]  o_out_proposer,
    output logic [7:0]  o_out_origin,
    output logic        o_last
);

    logic [QUEUE_DEPTH-1:0] r_valid, r_ready;
    logic [7:0]  r_snd  [QUEUE_DEPTH];
    logic [31:0] r_msg  [QUEUE_DEPTH];
    logic [31:0] r_seq  [QUEUE_DEPTH];
    logic [7:0]  r_prop [QUEUE_DEPTH];
    logic [7:0]  r_orig [QUEUE_DEPTH];

    logic        r_req;
    logic [7:0]  r_isnd, r_iprop, r_iorig;
    logic [31:0] r_imsg, r_iseq;

    logic [IDX_W-1:0] r_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_hit;

    logic             cand, better, last_slot;
    logic [IDX_W-1:0] tgt;

    assign last_slot = (r_idx == IDX_W'(QUEUE_DEPTH - 1));

    // The slot to update: an earlier hit, or the slot examined in this cycle.
    assign tgt = r_found ? r_hit : r_idx;

    // Candidate test for the slot under the scan pointer.
    always_comb begin
        cand   = (r_req == REQ_ADD) && !r_valid[r_idx];
        better = 1'b0;
        if (r_valid[r_idx]) begin
            if (r_seq[r_idx] != r_seq[r_hit]) begin
                better = r_seq[r_idx] < r_seq[r_hit];
            end else if (r_ready[r_idx] != r_ready[r_hit]) begin
                better = (r_ready[r_idx] == UNDELIVERABLE);
            end else begin
                better = r_prop[r_idx] < r_prop[r_hit];
            end
        end
    end

    logic matchs;
    assign matchs = r_valid[r_idx] && r_snd[r_idx] == r_isnd && r_msg[r_idx] == r_imsg;

    logic r_head_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ready     <= '0;
            r_found     <= 1'b0;
            r_idx       <= '0;
            r_hit       <= '0;
            r_head_mode <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_head || i_cmd.emit_stat;
            if (i_cmd.load) begin
                r_req   <= i_req_type;
                r_isnd  <= i_sender_id;
                r_imsg  <= i_msg_id;
                r_iseq  <= i_seq_num;
                r_iprop <= i_proposer_id;
                r_iorig <= i_origin_process;
                r_head_mode <= 1'b0;
            end
            if (i_cmd.scan_clr) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (!r_head_mode) begin
                    if (!r_found && ((r_req == REQ_ADD) ? cand : matchs)) begin
                        r_found <= 1'b1;
                        r_hit   <= r_idx;
                    end
                end else if (r_valid[r_idx] && (!r_found || better)) begin
                    r_found <= 1'b1;
                    r_hit   <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.do_add) begin
                r_valid[tgt] <= 1'b1;
                r_ready[tgt] <= UNDELIVERABLE;
                r_snd[tgt]   <= r_isnd;
                r_msg[tgt]   <= r_imsg;
                r_seq[tgt]   <= r_iseq;
                r_prop[tgt]  <= r_iprop;
                r_orig[tgt]  <= r_iorig;
            end
            if (i_cmd.do_mark) begin
                r_seq[tgt]   <= r_iseq;
                r_prop[tgt]  <= r_iprop;
                r_ready[tgt] <= DELIVERABLE;
                r_head_mode  <= 1'b1;
            end
            if (i_cmd.emit_head) begin
                r_valid[r_hit] <= 1'b0;
                r_ready[r_hit] <= UNDELIVERABLE;
                o_kind         <= KIND_MSG;
                o_status       <= ST_ADDED;
                o_out_sender   <= r_snd[r_hit];
                o_out_msg      <= r_msg[r_hit];
                o_out_seq      <= r_seq[r_hit];
                o_out_proposer <= r_prop[r_hit];
                o_out_origin   <= r_orig[r_hit];
                o_last         <= 1'b0;
            end
            if (i_cmd.emit_stat) begin
                o_kind         <= KIND_STATUS;
                o_status       <= i_cmd.stat_code;
                o_out_sender   <= '0;
                o_out_msg      <= '0;
                o_out_seq      <= '0;
                o_out_proposer <= '0;
                o_out_origin   <= '0;
                o_last         <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.req_type  = r_req;
        o_sts.scan_done = last_slot;
        o_sts.found     = r_found || ((r_req == REQ_ADD) ? cand : matchs);
        o_sts.head_ok   = r_found && r_valid[r_hit] && (r_ready[r_hit] == DELIVERABLE);
    end

endmodule

FILE: hw/rtl/total_order_holdback_queue.sv
// Top level of the total-order hold-back queue.
// A request is a single transfer: drive the request fields and raise
// start while busy is low; the request is taken at that clock edge.
// An add looks for the lowest free slot and stores the message as
// undeliverable. A mark looks for the lowest slot holding the same sender
// and message id, sets its final sequence and proposer and marks it
// deliverable. After a successful mark the queue drains: the head in
// sequence order is found by a scan of all slots, one slot per cycle, and
// while it is deliverable it leaves as a message item, at most DRAIN_LIMIT per mark.
// Every request ends with one status item that carries o_last.
// Each result transfer is shown for exactly one cycle with o_valid high;
// the receiver cannot stall, so the block never waits on the output side.
// An add or an unmatched mark needs one scan of all slots before its status.
// A matched mark adds one full head scan per drained message and a final
// scan that finds the head undeliverable or the drain limit reached.
// One request at a time: the next one can be taken in the status cycle.
// Synchronous reset empties the queue and returns the controller to idle.
module total_order_holdback_queue
    import thq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_sender_id,
    input  logic [31:0] i_msg_id,
    input  logic [31:0] i_seq_num,
    input  logic [7:0]  i_proposer_id,
    input  logic [7:0]  i_origin_process,
    output logic        o_valid,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_out_sender,
    output logic [31:0] o_out_msg,
    output logic [31:0] o_out_seq,
    output logic [7:0]  o_out_proposer,
    output logic [7:0]  o_out_origin,
    output logic        o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of the scan, drain and status steps.
    thq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Slot storage and the result register.
    thq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_type       (i_req_type),
        .i_sender_id      (i_sender_id),
        .i_msg_id         (i_msg_id),
        .i_seq_num        (i_seq_num),
        .i_proposer_id    (i_proposer_id),
        .i_origin_process (i_origin_process),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_out_sender     (o_out_sender),
        .o_out_msg        (o_out_msg),
        .o_out_seq        (o_out_seq),
        .o_out_proposer   (o_out_proposer),
        .o_out_origin     (o_out_origin),
        .o_last           (o_last)
    );

    // A status item always carries the last flag and a message item never does.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == o_kind)) else $error("last flag disagrees with kind");

    // The block is already idle in the cycle that a status transfer is shown.
    a_stat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy) else $error("busy after status");

    // An accepted request makes the block busy in the following cycle.
    a_no_start_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the total-order hold-back queue.
module testbench
    import thq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One request as driven on the input ports.
    typedef struct {
        logic        req_type;
        logic [7:0]  sender;
        logic [31:0] msg;
        logic [31:0] seq;
        logic [7:0]  proposer;
        logic [7:0]  origin;
    } t_request;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  sender;
        logic [31:0] msg;
        logic [31:0] seq;
        logic [7:0]  proposer;
        logic [7:0]  origin;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = REQ_ADD;
    logic [7:0]  i_sender_id = '0;
    logic [31:0] i_msg_id = '0;
    logic [31:0] i_seq_num = '0;
    logic [7:0]  i_proposer_id = '0;
    logic [7:0]  i_origin_process = '0;
    logic        o_valid;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [7:0]  o_out_sender;
    logic [31:0] o_out_msg;
    logic [31:0] o_out_seq;
    logic [7:0]  o_out_proposer;
    logic [7:0]  o_out_origin;
    logic        o_last;

    total_order_holdback_queue i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Mirror of the hold-back queue contents.
    logic        held_valid    [QUEUE_DEPTH];
    logic        held_ready    [QUEUE_DEPTH];
    logic [7:0]  held_sender   [QUEUE_DEPTH];
    logic [31:0] held_msg      [QUEUE_DEPTH];
    logic [31:0] held_seq      [QUEUE_DEPTH];
    logic [7:0]  held_proposer [QUEUE_DEPTH];
    logic [7:0]  held_origin   [QUEUE_DEPTH];

    t_request pending_requests[$];
    t_result  expected_deliveries[$];
    int       error_count = 0;
    bit       calm_phase;
    bit       stimulus_done = 1'b0;
    bit       req_taken = 1'b0;

    function automatic void queue_request(t_request rq);
        pending_requests = {pending_requests, rq};
    endfunction

    function automatic void expect_result(t_result r);
        expected_deliveries = {expected_deliveries, r};
    endfunction

    // Strict queue order: sequence, undeliverable first, proposer, slot index.
    function automatic bit comes_first(int a, int b);
        if (held_seq[a] != held_seq[b]) return held_seq[a] < held_seq[b];
        if (held_ready[a] != held_ready[b]) return held_ready[a] == UNDELIVERABLE;
        if (held_proposer[a] != held_proposer[b])
            return held_proposer[a] < held_proposer[b];
        return a < b;
    endfunction

    function automatic t_result status_item(logic [1:0] code);
        t_result r;
        r = '{kind: KIND_STATUS, status: code, sender: '0, msg: '0, seq: '0,
              proposer: '0, origin: '0, last: 1'b1};
        return r;
    endfunction

    // Applies one accepted request to the mirror and queues what it yields.
    task automatic apply_request(t_request rq);
        int      slot;
        int      head;
        int      drained;
        t_result r;
        slot = -1;
        drained = 0;
        if (rq.req_type == REQ_ADD) begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (!held_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
                expect_result(status_item(ST_FULL));
                return;
            end
            held_valid[slot] = 1'b1;
            held_ready[slot] = UNDELIVERABLE;
            held_sender[slot] = rq.sender;
            held_msg[slot] = rq.msg;
            held_seq[slot] = rq.seq;
            held_proposer[slot] = rq.proposer;
            held_origin[slot] = rq.origin;
            expect_result(status_item(ST_ADDED));
            return;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (slot < 0 && held_valid[i] && held_sender[i] == rq.sender
                && held_msg[i] == rq.msg) slot = i;
        if (slot < 0) begin
            expect_result(status_item(ST_NOT_FOUND));
            return;
        end
        held_seq[slot] = rq.seq;
        held_proposer[slot] = rq.proposer;
        held_ready[slot] = DELIVERABLE;
        // Drain deliverable heads, bounded per request.
        while (drained < DRAIN_LIMIT) begin
            head = -1;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (held_valid[i] && (head < 0 || comes_first(i, head))) head = i;
            if (head < 0 || held_ready[head] != DELIVERABLE) break;
            r = '{kind: KIND_MSG, status: '0, sender: held_sender[head],
                  msg: held_msg[head], seq: held_seq[head],
                  proposer: held_proposer[head], origin: held_origin[head],
                  last: 1'b0};
            expect_result(r);
            held_valid[head] = 1'b0;
            held_ready[head] = UNDELIVERABLE;
            drained++;
        end
        expect_result(status_item(ST_MARKED));
    endtask

    // Driver: presents queued requests with random idle bursts outside the calm phase.
    // A request stays on the ports until the monitor has seen it taken.
    int idle_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !req_taken)) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                if (!calm_phase && $urandom_range(0, 4) == 0) begin
                    idle_left <= $urandom_range(0, 4);
                    start <= 1'b0;
                end else begin
                    t_request rq;
                    rq = pending_requests.pop_front();
                    i_req_type <= rq.req_type;
                    i_sender_id <= rq.sender;
                    i_msg_id <= rq.msg;
                    i_seq_num <= rq.seq;
                    i_proposer_id <= rq.proposer;
                    i_origin_process <= rq.origin;
                    start <= 1'b1;
                end
            end else begin
                start <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each result.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy)
                apply_request('{i_req_type, i_sender_id, i_msg_id, i_seq_num,
                                i_proposer_id, i_origin_process});
            if (o_valid) begin
                t_result got, exp_r;
                got = '{o_kind, o_status, o_out_sender, o_out_msg, o_out_seq,
                        o_out_proposer, o_out_origin, o_last};
                if (expected_deliveries.size() == 0) begin
                    $display("%0t: mismatch expected no result actual %p",
                             $realtime, got);
                    error_count++;
                end else begin
                    exp_r = expected_deliveries.pop_front();
                    if (got != exp_r) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, exp_r, got);
                        error_count++;
                    end
                end
            end
        end
    end

    // Random fields; ids drawn from a small pool so marks often match.
    function automatic t_request rand_request(logic kind);
        t_request rq;
        rq.req_type = kind;
        rq.sender = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        rq.msg = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 7));
        rq.seq = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 20));
        rq.proposer = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 3));
        rq.origin = 8'($urandom);
        return rq;
    endfunction

    function automatic t_request make_req(logic kind, logic [7:0] snd, logic [31:0] msg,
                                          logic [31:0] seq, logic [7:0] prop,
                                          logic [7:0] orig);
        t_request rq;
        rq = '{kind, snd, msg, seq, prop, orig};
        return rq;
    endfunction

    initial begin
        t_request rq;
        calm_phase = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            held_valid[i] = 1'b0;
            held_ready[i] = UNDELIVERABLE;
        end
        // Directed: mark on empty queue, extreme values, equal keys,
        // fill to full, then release of the head of the order.
        queue_request(make_req(REQ_MARK, 8'hFF, '1, '1, 8'hFF, 8'hFF));
        queue_request(make_req(REQ_ADD, 8'hFF, '1, '1, 8'hFF, 8'hFF));
        queue_request(make_req(REQ_ADD, 8'h00, '0, '0, 8'h00, 8'h00));
        queue_request(make_req(REQ_ADD, 8'h00, '0, 32'd5, 8'h01, 8'hAA));
        // Mark of the duplicate key hits the lower slot; head stays undeliverable.
        queue_request(make_req(REQ_MARK, 8'h00, '0, 32'd5, 8'h01, 8'h55));
        queue_request(make_req(REQ_MARK, 8'h00, '0, 32'd5, 8'h01, 8'h00));
        for (int i = 0; i < 12; i++)
            queue_request(make_req(REQ_ADD, 8'(i + 1), 32'(i), 32'd7,
                                   8'(i % 3), 8'(i)));
        queue_request(make_req(REQ_ADD, 8'h12, 32'h34, 32'd1, 8'd0, 8'd0));
        // Equal keys among several entries, then release the top of the order.
        queue_request(make_req(REQ_MARK, 8'd1, 32'd0, 32'd7, 8'd0, 8'd0));
        queue_request(make_req(REQ_MARK, 8'd2, 32'd1, 32'd7, 8'd0, 8'd0));
        queue_request(make_req(REQ_MARK, 8'hFF, '1, 32'd0, 8'd0, 8'd0));
        // Random part: adds and marks, each add followed at random by a mark of the same message.
        for (int n = 0; n < 200; n++) begin
            rq = rand_request(1'($urandom_range(0, 1)));
            queue_request(rq);
            if (rq.req_type == REQ_ADD && $urandom_range(0, 1))
                queue_request(make_req(REQ_MARK, rq.sender, rq.msg,
                                       $urandom_range(0, 20),
                                       8'($urandom_range(0, 3)), 8'($urandom)));
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_requests.size() < 40);
        calm_phase = 1'b1;
        wait (stimulus_done && !busy && expected_deliveries.size() == 0);
        repeat (2 * (QUEUE_DEPTH + 2)) @(posedge i_clk);
        if (error_count == 0 && expected_deliveries.size() == 0)
            $display("total_order_holdback_queue test passed");
        else
            $display("total_order_holdback_queue test failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #20ms;
        $display("total_order_holdback_queue test failed");
        $finish;
    end

endmodule
